// ----- src/cc20_pkg.sv -----
`default_nettype none
package cc20_pkg;

	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_01   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_23   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_45   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_67   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_01 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_2  = 3'd5;

	localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
		32'h3320646e, 32'h61707865};

	// One line of the quarter round per step: add, xor, rotate.
	localparam logic [1:0] LINE_AB16 = 2'd0;
	localparam logic [1:0] LINE_CD12 = 2'd1;
	localparam logic [1:0] LINE_AB8  = 2'd2;
	localparam logic [1:0] LINE_CD7  = 2'd3;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [5:0]  pos;
		logic [31:0] ctr;
		logic        new_block;
	} entry_t;

	typedef enum logic [1:0] {
		ST_WAIT,
		ST_ROUND,
		ST_FEED,
		ST_EMIT
	} back_state_t;

	function automatic logic [31:0] qr_rot(logic [31:0] v, logic [1:0] line);
		logic [31:0] r;
		case (line)
			LINE_AB16: r = {v[15:0], v[31:16]};
			LINE_CD12: r = {v[19:0], v[31:20]};
			LINE_AB8:  r = {v[23:0], v[31:24]};
			LINE_CD7:  r = {v[24:0], v[31:25]};
			default:   r = v;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/cc20_in_if.sv -----
`default_nettype none
interface cc20_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface
`default_nettype wire

// ----- src/cc20_out_if.sv -----
`default_nettype none
interface cc20_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] result_byte;
	logic       result_last;

	modport source (output valid, output result_byte, output result_last, input ready);
	modport sink (input valid, input result_byte, input result_last, output ready);
endinterface
`default_nettype wire

// ----- src/cc20_front.sv -----
`default_nettype none
module cc20_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	cc20_in_if.sink            message,
	input  wire logic          full,
	output cc20_pkg::entry_t   push_entry,
	output logic               push
);

	logic [5:0]  pos_q;
	logic [31:0] ctr_q;

	assign message.ready = !full;
	assign push          = message.valid && !full;

	always_comb begin
		push_entry.data      = message.data_byte;
		push_entry.last      = message.end_of_message;
		push_entry.pos       = pos_q;
		push_entry.ctr       = ctr_q;
		push_entry.new_block = (pos_q == 6'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 6'd0;
			ctr_q <= 32'd0;
		end else if (push) begin
			if (message.end_of_message) begin
				pos_q <= 6'd0;
				ctr_q <= 32'd0;
			end else begin
				pos_q <= pos_q + 6'd1;
				if (pos_q == 6'd63) begin
					ctr_q <= ctr_q + 32'd1;
				end
			end
		end
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		push && message.end_of_message |=> pos_q == 6'd0 && ctr_q == 32'd0)
		else $error("message end did not restart the block counter");

endmodule
`default_nettype wire

// ----- src/cc20_fifo.sv -----
`default_nettype none
module cc20_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire cc20_pkg::entry_t  push_entry,
	output logic                   full,
	input  wire logic              pop,
	output cc20_pkg::entry_t       head,
	output logic                   head_valid
);

	localparam int unsigned QD    = cc20_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = $clog2(QD);
	localparam int unsigned CNT_W = $clog2(QD + 1);

	cc20_pkg::entry_t   slots_q [QD];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(QD));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QD - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QD - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QD))
		else $error("queue count beyond its depth");

endmodule
`default_nettype wire

// ----- src/cc20_back.sv -----
`default_nettype none
module cc20_back #(
	parameter int unsigned DOUBLE_ROUNDS = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cc20_pkg::entry_t  head,
	input  wire logic              head_valid,
	output logic                   pop,
	input  wire logic [7:0][31:0]  key,
	input  wire logic [2:0][31:0]  nonce,
	cc20_out_if.source             result
);

	localparam int unsigned NSTEPS = DOUBLE_ROUNDS * 8;
	localparam int unsigned STEP_W = $clog2(NSTEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);

	cc20_pkg::back_state_t state_q, state_d;
	logic [STEP_W-1:0]     step_q;
	logic [31:0]           words_q [16];
	logic [31:0]           init_w  [16];
	logic [31:0]           rnd_w   [16];
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;
	logic                  out_free;
	logic                  emit;
	logic                  load;
	logic [31:0]           ks_word;
	logic [7:0]            ks_byte;
	logic [1:0]            line;
	logic                  diag;
	logic [3:0]            ai, bi, ci, di;
	logic [31:0]           sum;

	assign out_free = !out_valid_q || result.ready;
	assign line     = step_q[1:0];
	assign diag     = step_q[2];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			init_w[i] = cc20_pkg::SIGMA[i];
		end
		for (int i = 0; i < 8; i++) begin
			init_w[4 + i] = key[i];
		end
		init_w[12] = head.ctr;
		for (int i = 0; i < 3; i++) begin
			init_w[13 + i] = nonce[i];
		end
	end

	// Four independent quarter rounds, one of their four lines per step.
	// On diagonal steps rows b, c and d are taken rotated by one, two and three.
	always_comb begin
		ai  = '0;
		bi  = '0;
		ci  = '0;
		di  = '0;
		sum = '0;
		rnd_w = words_q;
		for (int j = 0; j < 4; j++) begin
			ai = {2'd0, 2'(j)};
			bi = {2'd1, 2'(j + (diag ? 1 : 0))};
			ci = {2'd2, 2'(j + (diag ? 2 : 0))};
			di = {2'd3, 2'(j + (diag ? 3 : 0))};
			if (!line[0]) begin
				sum       = words_q[ai] + words_q[bi];
				rnd_w[ai] = sum;
				rnd_w[di] = cc20_pkg::qr_rot(words_q[di] ^ sum, line);
			end else begin
				sum       = words_q[ci] + words_q[di];
				rnd_w[ci] = sum;
				rnd_w[bi] = cc20_pkg::qr_rot(words_q[bi] ^ sum, line);
			end
		end
	end

	assign ks_word = words_q[head.pos[5:2]];
	assign ks_byte = ks_word[8 * head.pos[1:0] +: 8];

	always_comb begin
		state_d = state_q;
		case (state_q)
			cc20_pkg::ST_WAIT: begin
				if (head_valid && head.new_block) begin
					state_d = cc20_pkg::ST_ROUND;
				end
			end
			cc20_pkg::ST_ROUND: begin
				if (step_q == LAST_STEP) begin
					state_d = cc20_pkg::ST_FEED;
				end
			end
			cc20_pkg::ST_FEED: state_d = cc20_pkg::ST_EMIT;
			cc20_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = cc20_pkg::ST_WAIT;
				end
			end
			default: state_d = cc20_pkg::ST_WAIT;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		load = 1'b0;
		case (state_q)
			cc20_pkg::ST_WAIT: begin
				load = head_valid && head.new_block;
				emit = head_valid && !head.new_block && out_free;
			end
			cc20_pkg::ST_EMIT: emit = out_free;
			default: begin
				emit = 1'b0;
				load = 1'b0;
			end
		endcase
	end

	assign pop = emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cc20_pkg::ST_WAIT;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				step_q <= '0;
			end else if (state_q == cc20_pkg::ST_ROUND) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			words_q <= init_w;
		end else if (state_q == cc20_pkg::ST_ROUND) begin
			words_q <= rnd_w;
		end else if (state_q == cc20_pkg::ST_FEED) begin
			for (int i = 0; i < 16; i++) begin
				words_q[i] <= words_q[i] + init_w[i];
			end
		end
		if (emit) begin
			out_byte_q <= head.data ^ ks_byte;
			out_last_q <= head.last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.result_byte = out_byte_q;
	assign result.result_last = out_last_q;

	a_emit_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> head_valid)
		else $error("byte emitted with an empty queue");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cc20_pkg::ST_ROUND |-> step_q <= LAST_STEP)
		else $error("round step beyond the last round");

	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> state_q == cc20_pkg::ST_ROUND && step_q == '0)
		else $error("block build did not start from its first step");

endmodule
`default_nettype wire

// ----- src/chacha20_stream_cipher.sv -----
// Channel  | Dir  | Payload                          | Handshake
// message  | in   | data_byte[7:0], end_of_message   | valid/ready
// result   | out  | result_byte[7:0], result_last    | valid/ready
// config   | in   | cfg_index[2:0], cfg_data[63:0]   | cfg_we, no wait
//
// A byte inside a keystream block is XORed and registered straight from the wait state once
// the output register is free. The first byte of a block waits for the load, a step for each
// quarter-round line on the shared round unit, the feed-forward add, then the emit.
// A four-item queue lets the front keep taking bytes while a block is built.
// Reset clears the counters, the queue and the output register; the key and nonce read as zero.
// The output register holds its item while result.ready is low; the queue then fills and
// message.ready drops.
`default_nettype none
module chacha20_stream_cipher #(
	parameter int unsigned DOUBLE_ROUNDS = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	cc20_in_if.sink                                message,
	cc20_out_if.source                             result,
	input  wire logic                              cfg_we,
	input  wire logic [cc20_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [cc20_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [7:0][31:0] key_q;
	logic [2:0][31:0] nonce_q;
	cc20_pkg::entry_t push_entry;
	cc20_pkg::entry_t head;
	logic             push;
	logic             full;
	logic             pop;
	logic             head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			nonce_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				cc20_pkg::REG_KEY_01: begin
					key_q[0] <= cfg_data[31:0];
					key_q[1] <= cfg_data[63:32];
				end
				cc20_pkg::REG_KEY_23: begin
					key_q[2] <= cfg_data[31:0];
					key_q[3] <= cfg_data[63:32];
				end
				cc20_pkg::REG_KEY_45: begin
					key_q[4] <= cfg_data[31:0];
					key_q[5] <= cfg_data[63:32];
				end
				cc20_pkg::REG_KEY_67: begin
					key_q[6] <= cfg_data[31:0];
					key_q[7] <= cfg_data[63:32];
				end
				cc20_pkg::REG_NONCE_01: begin
					nonce_q[0] <= cfg_data[31:0];
					nonce_q[1] <= cfg_data[63:32];
				end
				cc20_pkg::REG_NONCE_2: nonce_q[2] <= cfg_data[31:0];
				default: begin
					key_q <= key_q;
				end
			endcase
		end
	end

	cc20_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.message    (message),
		.full       (full),
		.push_entry (push_entry),
		.push       (push)
	);

	cc20_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	cc20_back #(
		.DOUBLE_ROUNDS (DOUBLE_ROUNDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.key        (key_q),
		.nonce      (nonce_q),
		.result     (result)
	);

endmodule
`default_nettype wire
